// ===== hdl/cpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, payload types and codes of the convex polygon distance unit.
// Depends on nothing; the channel interfaces and the top level import it.
package cpd_pkg;

   localparam int COORD_BITS   = 16;
   localparam int MAX_VERTICES = 64;
   localparam int IDX_BITS     = 6;
   localparam int CNT_BITS     = 7;
   localparam int SUM_BITS     = 22;
   localparam int PT_BITS      = 17;
   localparam int AB_BITS      = 18;
   localparam int DIR_BITS     = 31;
   localparam int DIST_BITS    = 26;
   localparam int ITER_BITS    = 7;
   localparam int MA_BITS      = 32;
   localparam int MB_BITS      = 19;
   localparam int PROD_BITS    = MA_BITS + MB_BITS;
   localparam int ACC_BITS     = 74;
   localparam int NUM_BITS     = 88;
   localparam int Q_BITS       = 52;
   localparam int SAT_BIT      = 52;

   typedef logic [1:0]                   op_type;
   typedef logic [1:0]                   status_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [DIST_BITS-1:0]         dist_type;
   typedef logic [ITER_BITS-1:0]         iter_type;

   localparam op_type OP_ADD_FIRST  = 2'd0;
   localparam op_type OP_ADD_SECOND = 2'd1;
   localparam op_type OP_COMPUTE    = 2'd2;
   localparam op_type OP_NONE       = 2'd3;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_EMPTY   = 2'd1;
   localparam status_type STATUS_LIMIT   = 2'd2;
   localparam status_type STATUS_DROPPED = 2'd3;

   localparam iter_type LIMIT_RESET = 7'd32;
   localparam dist_type DIST_MAX    = '1;

endpackage

// ===== hdl/cpd_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for vertex requests, distance responses and the
// limit register write port. Depends on cpd_pkg for the payload types.
interface cpd_req_if;
   import cpd_pkg::*;
   logic      valid;
   logic      ready;
   op_type    operation;
   coord_type x_coord;
   coord_type y_coord;
   modport source (output valid, operation, x_coord, y_coord, input ready);
   modport sink (input valid, operation, x_coord, y_coord, output ready);
endinterface

interface cpd_rsp_if;
   import cpd_pkg::*;
   logic       valid;
   logic       ready;
   dist_type   distance;
   status_type status;
   iter_type   iterations;
   modport source (output valid, distance, status, iterations, input ready);
   modport sink (input valid, distance, status, iterations, output ready);
endinterface

interface cpd_csr_if;
   import cpd_pkg::*;
   logic     valid;
   logic     ready;
   iter_type iteration_limit;
   modport source (output valid, iteration_limit, input ready);
   modport sink (input valid, iteration_limit, output ready);
endinterface

// ===== hdl/convex_polygon_distance_unit.sv =====
`timescale 1ns / 1ps
// Convex polygon distance unit: vertex store, GJK sequencer and shared multiply unit.
// Depends on cpd_pkg and the channel interfaces in cpd_channels.sv.
//
// A vertex load word is taken while the unit is idle, and the unit stays ready after it.
// A compute word holds the request channel for the whole search, which runs on one
// shared 32 by 19 bit multiplier with an accumulator under a small sequencer. Each
// support search scans both polygons vertex by vertex and then picks the point; the
// start forms the start direction, runs two searches and finds the first nearest
// feature, and each refinement iteration adds one search, a norm test and the next
// nearest feature. The final distance takes squaring for an endpoint, or squaring and
// then restoring division for a segment feature, then, unless the quotient saturates,
// a square root and the hand-over of the word. The result word waits in an output
// register, so loads continue while it is pending.
module convex_polygon_distance_unit (
   input logic        clock,
   input logic        reset,
   cpd_req_if.sink    req_if,
   cpd_rsp_if.source  rsp_if,
   cpd_csr_if.sink    csr_if
);
   import cpd_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_INIT = 10'b0000000010,
      ST_SCAN = 10'b0000000100,
      ST_PICK = 10'b0000001000,
      ST_NEAR = 10'b0000010000,
      ST_NORM = 10'b0000100000,
      ST_SQR  = 10'b0001000000,
      ST_DIV  = 10'b0010000000,
      ST_ROOT = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   typedef enum logic [2:0] {
      PH_A   = 3'b001,
      PH_B   = 3'b010,
      PH_REF = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      FEAT_P0  = 3'b001,
      FEAT_P1  = 3'b010,
      FEAT_SEG = 3'b100
   } feat_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [1:0] {
      SH_0,
      SH_19,
      SH_36
   } acc_sh_type;

   localparam logic [Q_BITS-1:0] ROOT_START = Q_BITS'(1) << (Q_BITS - 2);
   localparam logic [6:0]        DIV_START  = 7'(NUM_BITS - 1);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   feat_type  feat_ff, feat_in;
   logic [2:0] step_ff, step_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic poly_ff, poly_in;

   logic [CNT_BITS-1:0] cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic signed [SUM_BITS-1:0] sx1_ff, sx1_in, sy1_ff, sy1_in;
   logic signed [SUM_BITS-1:0] sx2_ff, sx2_in, sy2_ff, sy2_in;
   logic drop_ff, drop_in;
   iter_type limit_ff, limit_in;

   logic [2*COORD_BITS-1:0] mem1 [MAX_VERTICES];
   logic [2*COORD_BITS-1:0] mem2 [MAX_VERTICES];
   logic [2*COORD_BITS-1:0] rd1_ff, rd2_ff;
   logic we1, we2;

   logic signed [DIR_BITS-1:0] dirx_ff, dirx_in, diry_ff, diry_in;
   logic signed [PROD_BITS-1:0] best_ff, best_in;
   coord_type bvx_ff, bvx_in, bvy_ff, bvy_in, v1x_ff, v1x_in, v1y_ff, v1y_in;
   logic signed [PT_BITS-1:0] s0x_ff, s0x_in, s0y_ff, s0y_in;
   logic signed [PT_BITS-1:0] s1x_ff, s1x_in, s1y_ff, s1y_in;
   logic signed [PT_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [36:0] work_ff, work_in;
   logic [35:0] ab2_ff, ab2_in, c_ff, c_in;
   iter_type it_ff, it_in;
   logic lim_ff, lim_in;

   logic signed [MA_BITS-1:0] mul_a;
   logic signed [MB_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in, acc_term;
   acc_op_type acc_op;
   acc_sh_type acc_sh;

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [35:0] rem_ff, rem_in;
   logic [6:0] dcnt_ff, dcnt_in;
   logic sat_ff, sat_in;
   logic [Q_BITS-1:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in;

   dist_type res_dist_ff, res_dist_in;
   status_type res_stat_ff, res_stat_in;
   logic rsp_valid_ff, rsp_valid_in;
   dist_type rsp_dist_ff, rsp_dist_in;
   status_type rsp_stat_ff, rsp_stat_in;
   iter_type rsp_iter_ff, rsp_iter_in;

   coord_type rdx, rdy, selx, sely;
   logic signed [MA_BITS-1:0] dsx, dsy;
   logic take, last;
   logic [CNT_BITS-1:0] ncur;
   logic signed [PT_BITS-1:0] aox, aoy, qx, qy;
   logic signed [AB_BITS-1:0] abx, aby;
   logic signed [36:0] cr;
   logic [17:0] c_lo, c_hi;
   logic [36:0] rem2, div_diff;
   logic div_ge;
   logic [Q_BITS:0] root_sum;
   logic root_ge;
   logic [Q_BITS-1:0] r_next;
   status_type fin_stat;
   logic out_free, is_seg;

   assign rdx  = poly_ff ? rd2_ff[2*COORD_BITS-1:COORD_BITS] : rd1_ff[2*COORD_BITS-1:COORD_BITS];
   assign rdy  = poly_ff ? rd2_ff[COORD_BITS-1:0] : rd1_ff[COORD_BITS-1:0];
   assign dsx  = poly_ff ? -MA_BITS'(dirx_ff) : MA_BITS'(dirx_ff);
   assign dsy  = poly_ff ? -MA_BITS'(diry_ff) : MA_BITS'(diry_ff);
   assign take = (idx_ff == '0) || ($signed(acc_ff[PROD_BITS-1:0]) > best_ff);
   assign selx = take ? rdx : bvx_ff;
   assign sely = take ? rdy : bvy_ff;
   assign ncur = poly_ff ? cnt2_ff : cnt1_ff;
   assign last = (CNT_BITS'(idx_ff) + CNT_BITS'(1)) == ncur;

   assign aox = -s0x_ff;
   assign aoy = -s0y_ff;
   assign abx = AB_BITS'(s1x_ff) - AB_BITS'(s0x_ff);
   assign aby = AB_BITS'(s1y_ff) - AB_BITS'(s0y_ff);
   assign cr  = acc_ff[36:0];
   assign qx  = (feat_ff == FEAT_P0) ? s0x_ff : s1x_ff;
   assign qy  = (feat_ff == FEAT_P0) ? s0y_ff : s1y_ff;
   assign c_lo = c_ff[17:0];
   assign c_hi = c_ff[35:18];
   assign is_seg = (feat_ff == FEAT_SEG);

   assign rem2     = {rem_ff, num_ff[NUM_BITS-1]};
   assign div_ge   = rem2 >= {1'b0, ab2_ff};
   assign div_diff = rem2 - {1'b0, ab2_ff};

   assign root_sum = {1'b0, r_ff} + {1'b0, bit_ff};
   assign root_ge  = {1'b0, v_ff} >= root_sum;
   assign r_next   = root_ge ? ((r_ff >> 1) + bit_ff) : (r_ff >> 1);

   assign fin_stat = drop_ff ? STATUS_DROPPED : (lim_ff ? STATUS_LIMIT : STATUS_OK);
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   always_comb begin
      acc_term = ACC_BITS'(prod_ff);
      case (acc_sh)
         SH_19:   acc_term = ACC_BITS'(prod_ff) <<< 19;
         SH_36:   acc_term = ACC_BITS'(prod_ff) <<< 36;
         default: acc_term = ACC_BITS'(prod_ff);
      endcase
      case (acc_op)
         ACC_LOAD: acc_in = acc_term;
         ACC_ADD:  acc_in = acc_ff + acc_term;
         ACC_SUB:  acc_in = acc_ff - acc_term;
         default:  acc_in = acc_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      feat_in  = feat_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      poly_in  = poly_ff;
      cnt1_in  = cnt1_ff;
      cnt2_in  = cnt2_ff;
      sx1_in   = sx1_ff;
      sy1_in   = sy1_ff;
      sx2_in   = sx2_ff;
      sy2_in   = sy2_ff;
      drop_in  = drop_ff;
      limit_in = limit_ff;
      dirx_in  = dirx_ff;
      diry_in  = diry_ff;
      best_in  = best_ff;
      bvx_in   = bvx_ff;
      bvy_in   = bvy_ff;
      v1x_in   = v1x_ff;
      v1y_in   = v1y_ff;
      s0x_in   = s0x_ff;
      s0y_in   = s0y_ff;
      s1x_in   = s1x_ff;
      s1y_in   = s1y_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      work_in  = work_ff;
      ab2_in   = ab2_ff;
      c_in     = c_ff;
      it_in    = it_ff;
      lim_in   = lim_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      sat_in   = sat_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      res_dist_in = res_dist_ff;
      res_stat_in = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_iter_in  = rsp_iter_ff;
      mul_a  = '0;
      mul_b  = '0;
      acc_op = ACC_HOLD;
      acc_sh = SH_0;
      we1    = 1'b0;
      we2    = 1'b0;

      if (csr_if.valid) begin
         limit_in = csr_if.iteration_limit;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               case (req_if.operation)
                  OP_ADD_FIRST: begin
                     if (cnt1_ff == CNT_BITS'(MAX_VERTICES)) begin
                        drop_in = 1'b1;
                     end else begin
                        we1     = 1'b1;
                        cnt1_in = cnt1_ff + CNT_BITS'(1);
                        sx1_in  = sx1_ff + SUM_BITS'(req_if.x_coord);
                        sy1_in  = sy1_ff + SUM_BITS'(req_if.y_coord);
                     end
                  end
                  OP_ADD_SECOND: begin
                     if (cnt2_ff == CNT_BITS'(MAX_VERTICES)) begin
                        drop_in = 1'b1;
                     end else begin
                        we2     = 1'b1;
                        cnt2_in = cnt2_ff + CNT_BITS'(1);
                        sx2_in  = sx2_ff + SUM_BITS'(req_if.x_coord);
                        sy2_in  = sy2_ff + SUM_BITS'(req_if.y_coord);
                     end
                  end
                  OP_COMPUTE: begin
                     it_in  = '0;
                     lim_in = 1'b0;
                     if (cnt1_ff == '0 || cnt2_ff == '0) begin
                        res_dist_in = '0;
                        res_stat_in = STATUS_EMPTY;
                        state_in    = ST_DONE;
                     end else begin
                        step_in  = '0;
                        state_in = ST_INIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INIT: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  mul_a = MA_BITS'(sx2_ff);
                  mul_b = MB_BITS'($signed({1'b0, cnt1_ff}));
               end
               3'd1: begin
                  acc_op = ACC_LOAD;
                  mul_a  = MA_BITS'(sx1_ff);
                  mul_b  = MB_BITS'($signed({1'b0, cnt2_ff}));
               end
               3'd2: begin
                  acc_op = ACC_SUB;
                  mul_a  = MA_BITS'(sy2_ff);
                  mul_b  = MB_BITS'($signed({1'b0, cnt1_ff}));
               end
               3'd3: begin
                  dirx_in = acc_ff[DIR_BITS-1:0];
                  acc_op  = ACC_LOAD;
                  mul_a   = MA_BITS'(sy1_ff);
                  mul_b   = MB_BITS'($signed({1'b0, cnt2_ff}));
               end
               3'd4: begin
                  acc_op = ACC_SUB;
               end
               default: begin
                  diry_in  = acc_ff[DIR_BITS-1:0];
                  phase_in = PH_A;
                  poly_in  = 1'b0;
                  idx_in   = '0;
                  step_in  = '0;
                  state_in = ST_SCAN;
               end
            endcase
         end

         ST_SCAN: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
               end
               3'd1: begin
                  mul_a = dsx;
                  mul_b = MB_BITS'(rdx);
               end
               3'd2: begin
                  acc_op = ACC_LOAD;
                  mul_a  = dsy;
                  mul_b  = MB_BITS'(rdy);
               end
               3'd3: begin
                  acc_op = ACC_ADD;
               end
               default: begin
                  step_in = '0;
                  if (take) begin
                     best_in = acc_ff[PROD_BITS-1:0];
                     bvx_in  = rdx;
                     bvy_in  = rdy;
                  end
                  if (!last) begin
                     idx_in = idx_ff + IDX_BITS'(1);
                  end else if (!poly_ff) begin
                     v1x_in  = selx;
                     v1y_in  = sely;
                     poly_in = 1'b1;
                     idx_in  = '0;
                  end else begin
                     px_in    = PT_BITS'(v1x_ff) - PT_BITS'(selx);
                     py_in    = PT_BITS'(v1y_ff) - PT_BITS'(sely);
                     state_in = ST_PICK;
                  end
               end
            endcase
         end

         ST_PICK: begin
            step_in = '0;
            case (phase_ff)
               PH_A: begin
                  s0x_in   = px_ff;
                  s0y_in   = py_ff;
                  dirx_in  = -DIR_BITS'(px_ff);
                  diry_in  = -DIR_BITS'(py_ff);
                  phase_in = PH_B;
                  poly_in  = 1'b0;
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
               PH_B: begin
                  if (px_ff == s0x_ff && py_ff == s0y_ff) begin
                     feat_in  = FEAT_P0;
                     state_in = ST_SQR;
                  end else begin
                     s1x_in   = px_ff;
                     s1y_in   = py_ff;
                     state_in = ST_NEAR;
                  end
               end
               default: begin
                  it_in = it_ff + ITER_BITS'(1);
                  if ((px_ff == s0x_ff && py_ff == s0y_ff) ||
                      (px_ff == s1x_ff && py_ff == s1y_ff)) begin
                     state_in = ST_SQR;
                  end else begin
                     state_in = ST_NORM;
                  end
               end
            endcase
         end

         ST_NEAR: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  mul_a = MA_BITS'(aox);
                  mul_b = MB_BITS'(abx);
               end
               3'd1: begin
                  acc_op = ACC_LOAD;
                  mul_a  = MA_BITS'(aoy);
                  mul_b  = MB_BITS'(aby);
               end
               3'd2: begin
                  acc_op = ACC_ADD;
                  mul_a  = MA_BITS'(abx);
                  mul_b  = MB_BITS'(abx);
               end
               3'd3: begin
                  work_in = acc_ff[36:0];
                  acc_op  = ACC_LOAD;
                  mul_a   = MA_BITS'(aby);
                  mul_b   = MB_BITS'(aby);
               end
               3'd4: begin
                  acc_op = ACC_ADD;
                  mul_a  = MA_BITS'(abx);
                  mul_b  = MB_BITS'(aoy);
               end
               3'd5: begin
                  ab2_in = acc_ff[35:0];
                  acc_op = ACC_LOAD;
                  mul_a  = MA_BITS'(aby);
                  mul_b  = MB_BITS'(aox);
               end
               3'd6: begin
                  acc_op = ACC_SUB;
               end
               default: begin
                  step_in = '0;
                  if (work_ff < 0) begin
                     feat_in = FEAT_P0;
                     dirx_in = DIR_BITS'(aox);
                     diry_in = DIR_BITS'(aoy);
                  end else if (work_ff > $signed({1'b0, ab2_ff})) begin
                     feat_in = FEAT_P1;
                     dirx_in = -DIR_BITS'(s1x_ff);
                     diry_in = -DIR_BITS'(s1y_ff);
                  end else begin
                     feat_in = FEAT_SEG;
                     if (cr > 0) begin
                        c_in    = cr[35:0];
                        dirx_in = -DIR_BITS'(aby);
                        diry_in = DIR_BITS'(abx);
                     end else begin
                        c_in    = 36'(-cr);
                        dirx_in = DIR_BITS'(aby);
                        diry_in = -DIR_BITS'(abx);
                     end
                  end
                  if (work_ff >= 0 && work_ff <= $signed({1'b0, ab2_ff}) && cr == 0) begin
                     res_dist_in = '0;
                     res_stat_in = fin_stat;
                     state_in    = ST_DONE;
                  end else if (it_ff >= limit_ff) begin
                     lim_in   = 1'b1;
                     state_in = ST_SQR;
                  end else begin
                     phase_in = PH_REF;
                     poly_in  = 1'b0;
                     idx_in   = '0;
                     state_in = ST_SCAN;
                  end
               end
            endcase
         end

         ST_NORM: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  mul_a = MA_BITS'(s0x_ff);
                  mul_b = MB_BITS'(s0x_ff);
               end
               3'd1: begin
                  acc_op = ACC_LOAD;
                  mul_a  = MA_BITS'(s0y_ff);
                  mul_b  = MB_BITS'(s0y_ff);
               end
               3'd2: begin
                  acc_op = ACC_ADD;
                  mul_a  = MA_BITS'(s1x_ff);
                  mul_b  = MB_BITS'(s1x_ff);
               end
               3'd3: begin
                  work_in = acc_ff[36:0];
                  acc_op  = ACC_LOAD;
                  mul_a   = MA_BITS'(s1y_ff);
                  mul_b   = MB_BITS'(s1y_ff);
               end
               3'd4: begin
                  acc_op = ACC_ADD;
               end
               default: begin
                  if (work_ff > $signed(acc_ff[36:0])) begin
                     s0x_in = s1x_ff;
                     s0y_in = s1y_ff;
                  end
                  s1x_in   = px_ff;
                  s1y_in   = py_ff;
                  step_in  = '0;
                  state_in = ST_NEAR;
               end
            endcase
         end

         ST_SQR: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  mul_a = is_seg ? MA_BITS'($signed({1'b0, c_lo})) : MA_BITS'(qx);
                  mul_b = is_seg ? MB_BITS'($signed({1'b0, c_lo})) : MB_BITS'(qx);
               end
               3'd1: begin
                  acc_op = ACC_LOAD;
                  mul_a  = is_seg ? MA_BITS'($signed({1'b0, c_hi})) : MA_BITS'(qy);
                  mul_b  = is_seg ? MB_BITS'($signed({1'b0, c_lo})) : MB_BITS'(qy);
               end
               3'd2: begin
                  acc_op = ACC_ADD;
                  acc_sh = is_seg ? SH_19 : SH_0;
                  mul_a  = MA_BITS'($signed({1'b0, c_hi}));
                  mul_b  = MB_BITS'($signed({1'b0, c_hi}));
               end
               3'd3: begin
                  if (is_seg) begin
                     acc_op = ACC_ADD;
                     acc_sh = SH_36;
                  end else begin
                     v_in     = {acc_ff[35:0], 16'd0};
                     r_in     = '0;
                     bit_in   = ROOT_START;
                     state_in = ST_ROOT;
                  end
               end
               default: begin
                  num_in   = {acc_ff[71:0], 16'd0};
                  rem_in   = '0;
                  dcnt_in  = DIV_START;
                  sat_in   = 1'b0;
                  v_in     = '0;
                  state_in = ST_DIV;
               end
            endcase
         end

         ST_DIV: begin
            rem_in  = div_ge ? div_diff[35:0] : rem2[35:0];
            num_in  = num_ff << 1;
            v_in    = {v_ff[Q_BITS-2:0], div_ge};
            dcnt_in = dcnt_ff - 7'd1;
            if (div_ge && dcnt_ff >= 7'(SAT_BIT)) begin
               sat_in = 1'b1;
            end
            if (dcnt_ff == '0) begin
               if (sat_ff) begin
                  res_dist_in = DIST_MAX;
                  res_stat_in = fin_stat;
                  state_in    = ST_DONE;
               end else begin
                  r_in     = '0;
                  bit_in   = ROOT_START;
                  state_in = ST_ROOT;
               end
            end
         end

         ST_ROOT: begin
            if (root_ge) begin
               v_in = v_ff - root_sum[Q_BITS-1:0];
            end
            r_in   = r_next;
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               res_dist_in = r_next[DIST_BITS-1:0];
               res_stat_in = fin_stat;
               state_in    = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = res_dist_ff;
               rsp_stat_in  = res_stat_ff;
               rsp_iter_in  = it_ff;
               cnt1_in      = '0;
               cnt2_in      = '0;
               sx1_in       = '0;
               sy1_in       = '0;
               sx2_in       = '0;
               sy2_in       = '0;
               drop_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         mem1[cnt1_ff[IDX_BITS-1:0]] <= {req_if.x_coord, req_if.y_coord};
      end
      if (we2) begin
         mem2[cnt2_ff[IDX_BITS-1:0]] <= {req_if.x_coord, req_if.y_coord};
      end
      rd1_ff <= mem1[idx_ff];
      rd2_ff <= mem2[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cnt1_ff      <= '0;
         cnt2_ff      <= '0;
         sx1_ff       <= '0;
         sy1_ff       <= '0;
         sx2_ff       <= '0;
         sy2_ff       <= '0;
         drop_ff      <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt1_ff      <= cnt1_in;
         cnt2_ff      <= cnt2_in;
         sx1_ff       <= sx1_in;
         sy1_ff       <= sy1_in;
         sx2_ff       <= sx2_in;
         sy2_ff       <= sy2_in;
         drop_ff      <= drop_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      feat_ff     <= feat_in;
      idx_ff      <= idx_in;
      poly_ff     <= poly_in;
      dirx_ff     <= dirx_in;
      diry_ff     <= diry_in;
      best_ff     <= best_in;
      bvx_ff      <= bvx_in;
      bvy_ff      <= bvy_in;
      v1x_ff      <= v1x_in;
      v1y_ff      <= v1y_in;
      s0x_ff      <= s0x_in;
      s0y_ff      <= s0y_in;
      s1x_ff      <= s1x_in;
      s1y_ff      <= s1y_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      work_ff     <= work_in;
      ab2_ff      <= ab2_in;
      c_ff        <= c_in;
      it_ff       <= it_in;
      lim_ff      <= lim_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      sat_ff      <= sat_in;
      v_ff        <= v_in;
      r_ff        <= r_in;
      bit_ff      <= bit_in;
      res_dist_ff <= res_dist_in;
      res_stat_ff <= res_stat_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_iter_ff <= rsp_iter_in;
   end

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign csr_if.ready      = 1'b1;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.distance   = rsp_dist_ff;
   assign rsp_if.status     = rsp_stat_ff;
   assign rsp_if.iterations = rsp_iter_ff;

   // A new result word only ever comes from the hand-over state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside the hand-over state");

   // The division remainder always stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < ab2_ff))
      else $error("division remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> $onehot(bit_ff))
      else $error("square root bit weight lost");

   assert property (@(posedge clock) disable iff (reset)
      (cnt1_ff <= CNT_BITS'(MAX_VERTICES)) && (cnt2_ff <= CNT_BITS'(MAX_VERTICES)))
      else $error("vertex count beyond store depth");

endmodule

// ===== verif/convex_polygon_distance_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the convex polygon distance unit: watches the request, response and
// limit channels, predicts each distance word and compares it. Depends on cpd_pkg.
module convex_polygon_distance_unit_checker
   import cpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  op_type     req_operation,
   input  coord_type  req_x,
   input  coord_type  req_y,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  dist_type   rsp_distance,
   input  status_type rsp_status,
   input  iter_type   rsp_iterations,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  iter_type   csr_limit,
   output int         failures,
   output int         pending
);

   typedef struct packed {
      dist_type   distance;
      status_type status;
      iter_type   iterations;
   } answer_type;

   answer_type    answers[$];
   longint        poly_x[2][MAX_VERTICES];
   longint        poly_y[2][MAX_VERTICES];
   int            poly_n[2];
   longint        sum_x[2];
   longint        sum_y[2];
   bit            overflowed;
   int            limit_value;

   function automatic longint root_of(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // floor(256 * sqrt(num / den)), saturated to the distance width.
   function automatic dist_type scaled_root(logic [127:0] num, longint unsigned den);
      logic [127:0] q;
      longint unsigned r;
      if (den == 0) return '0;
      q = (num << 16) / den;
      if (q >= (128'd1 << 52)) return DIST_MAX;
      r = root_of(q[63:0]);
      return (r > DIST_MAX) ? DIST_MAX : r[DIST_BITS-1:0];
   endfunction

   function automatic dist_type point_distance(longint px, longint py);
      return scaled_root(128'(px * px + py * py), 1);
   endfunction

   function automatic int farthest(int p, longint dx, longint dy);
      int best;
      longint bd, d;
      best = 0;
      bd = dx * poly_x[p][0] + dy * poly_y[p][0];
      for (int i = 1; i < poly_n[p]; i++) begin
         d = dx * poly_x[p][i] + dy * poly_y[p][i];
         if (d > bd) begin
            bd = d;
            best = i;
         end
      end
      return best;
   endfunction

   function automatic void support_point(input longint dx, input longint dy,
                                         output longint px, output longint py);
      int i, j;
      i = farthest(0, dx, dy);
      j = farthest(1, -dx, -dy);
      px = poly_x[0][i] - poly_x[1][j];
      py = poly_y[0][i] - poly_y[1][j];
   endfunction

   // Nearest feature of segment AB to the origin; sets touching when the origin is on it.
   function automatic void nearest_feature(input longint ax, input longint ay,
                                           input longint bx, input longint by,
                                           output longint dx, output longint dy,
                                           output dist_type feat_dist, output bit touching);
      longint abx, aby, t, ab2, cr, c;
      abx = bx - ax;
      aby = by - ay;
      t = -ax * abx - ay * aby;
      ab2 = abx * abx + aby * aby;
      touching = 0;
      dx = 0;
      dy = 0;
      if (t < 0) begin
         dx = -ax;
         dy = -ay;
         feat_dist = point_distance(ax, ay);
      end else if (t > ab2) begin
         dx = -bx;
         dy = -by;
         feat_dist = point_distance(bx, by);
      end else begin
         cr = abx * (-ay) - aby * (-ax);
         if (cr == 0) begin
            feat_dist = '0;
            touching = 1;
         end else begin
            if (cr > 0) begin
               dx = -aby;
               dy = abx;
               c = cr;
            end else begin
               dx = aby;
               dy = -abx;
               c = -cr;
            end
            feat_dist = scaled_root(128'(c) * 128'(c), ab2);
         end
      end
   endfunction

   function automatic answer_type run_search();
      answer_type res;
      longint dx, dy, ax, ay, bx, by, s0x, s0y, s1x, s1y, px, py;
      int iters;
      bit limited, touching;
      dist_type feat_dist;
      res = '0;
      if (poly_n[0] == 0 || poly_n[1] == 0) begin
         res.status = STATUS_EMPTY;
         return res;
      end
      dx = poly_n[0] * sum_x[1] - poly_n[1] * sum_x[0];
      dy = poly_n[0] * sum_y[1] - poly_n[1] * sum_y[0];
      while (dx >= (64'sd1 << 30) || dx <= -(64'sd1 << 30) ||
             dy >= (64'sd1 << 30) || dy <= -(64'sd1 << 30)) begin
         dx = (dx < 0) ? -((-dx) >>> 1) : dx >>> 1;
         dy = (dy < 0) ? -((-dy) >>> 1) : dy >>> 1;
      end
      iters = 0;
      limited = 0;
      support_point(dx, dy, ax, ay);
      support_point(-ax, -ay, bx, by);
      if (ax == bx && ay == by) begin
         feat_dist = point_distance(ax, ay);
      end else begin
         s0x = ax; s0y = ay; s1x = bx; s1y = by;
         forever begin
            nearest_feature(s0x, s0y, s1x, s1y, dx, dy, feat_dist, touching);
            if (touching) break;
            if (iters >= limit_value) begin
               limited = 1;
               break;
            end
            support_point(dx, dy, px, py);
            iters++;
            if ((px == s0x && py == s0y) || (px == s1x && py == s1y)) break;
            if (s0x * s0x + s0y * s0y > s1x * s1x + s1y * s1y) begin
               s0x = s1x;
               s0y = s1y;
            end
            s1x = px;
            s1y = py;
         end
      end
      res.distance   = feat_dist;
      res.status     = overflowed ? STATUS_DROPPED : (limited ? STATUS_LIMIT : STATUS_OK);
      res.iterations = iter_type'(iters);
      return res;
   endfunction

   assign pending = answers.size();

   always @(posedge clock) begin
      answer_type want;
      int p;
      if (reset) begin
         answers.delete();
         poly_n = '{0, 0};
         sum_x = '{0, 0};
         sum_y = '{0, 0};
         overflowed = 0;
         limit_value = LIMIT_RESET;
         failures <= 0;
      end else begin
         if (csr_valid && csr_ready) limit_value = csr_limit;
         if (rsp_valid && rsp_ready) begin
            if (answers.size() == 0) begin
               $display("%0t: unexpected word dist=%0d status=%0d iter=%0d", $time,
                        rsp_distance, rsp_status, rsp_iterations);
               failures <= failures + 1;
            end else begin
               want = answers.pop_front();
               if (want.distance !== rsp_distance || want.status !== rsp_status ||
                   want.iterations !== rsp_iterations) begin
                  $display("%0t: expected dist=%0d status=%0d iter=%0d, got %0d %0d %0d",
                           $time, want.distance, want.status, want.iterations,
                           rsp_distance, rsp_status, rsp_iterations);
                  failures <= failures + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_operation == OP_ADD_FIRST || req_operation == OP_ADD_SECOND) begin
               p = (req_operation == OP_ADD_FIRST) ? 0 : 1;
               if (poly_n[p] >= MAX_VERTICES) begin
                  overflowed = 1;
               end else begin
                  poly_x[p][poly_n[p]] = req_x;
                  poly_y[p][poly_n[p]] = req_y;
                  poly_n[p]++;
                  sum_x[p] += req_x;
                  sum_y[p] += req_y;
               end
            end else if (req_operation == OP_COMPUTE) begin
               answers.insert(answers.size(), run_search());
               poly_n = '{0, 0};
               sum_x = '{0, 0};
               sum_y = '{0, 0};
               overflowed = 0;
            end
         end
      end
   end

endmodule

// ===== verif/convex_polygon_distance_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the convex polygon distance unit: clock, reset, polygon stimulus,
// limit writes and the verdict. Depends on cpd_pkg, cpd_channels and the checker.
module convex_polygon_distance_unit_tb;
   import cpd_pkg::*;

   localparam int WATCHDOG = 200000;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   idle_cycles;
   bit   hold_off;
   bit   done;

   cpd_req_if req_if ();
   cpd_rsp_if rsp_if ();
   cpd_csr_if csr_if ();

   convex_polygon_distance_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   convex_polygon_distance_unit_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_operation  (req_if.operation),
      .req_x          (req_if.x_coord),
      .req_y          (req_if.y_coord),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_distance   (rsp_if.distance),
      .rsp_status     (rsp_if.status),
      .rsp_iterations (rsp_if.iterations),
      .csr_valid      (csr_if.valid),
      .csr_ready      (csr_if.ready),
      .csr_limit      (csr_if.iteration_limit),
      .failures       (failures),
      .pending        (pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   int burst_left;
   int gap_left;

   // Sends one word; between words the sender idles in bursts and gaps.
   task automatic send_word(input op_type op, input coord_type x, input coord_type y);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      while (gap_left > 0) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         gap_left--;
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.x_coord   <= x;
      req_if.y_coord   <= y;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(input iter_type value);
      csr_if.valid           <= 1'b1;
      csr_if.iteration_limit <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   function automatic coord_type random_coord(int span);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return coord_type'($urandom);
      if (r == 1) return ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
      return coord_type'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // A random pair of polygons: points around two centres, then a compute.
   task automatic send_pair(input int n1, input int n2);
      int cx, cy, span;
      span = $urandom_range(5, 2000);
      cx = $signed($urandom_range(0, 20000)) - 10000;
      cy = $signed($urandom_range(0, 20000)) - 10000;
      for (int i = 0; i < n1; i++)
         send_word(OP_ADD_FIRST, coord_type'(cx + $signed($urandom_range(0, 2 * span)) - span),
                   coord_type'(cy + $signed($urandom_range(0, 2 * span)) - span));
      for (int i = 0; i < n2; i++)
         send_word(OP_ADD_SECOND, random_coord(span), random_coord(span));
      if ($urandom_range(0, 9) == 0) send_word(OP_NONE, coord_type'($urandom), coord_type'($urandom));
      send_word(OP_COMPUTE, coord_type'($urandom), coord_type'($urandom));
   endtask

   initial begin
      reset          = 1'b1;
      done           = 0;
      burst_left     = 0;
      gap_left       = 0;
      req_if.valid   <= 1'b0;
      req_if.operation <= OP_NONE;
      req_if.x_coord <= '0;
      req_if.y_coord <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.iteration_limit <= LIMIT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty polygons, a touching pair, extremes, unused operation.
      send_word(OP_COMPUTE, '0, '0);
      send_word(OP_ADD_FIRST, 16'sh7fff, 16'sh7fff);
      send_word(OP_COMPUTE, '0, '0);
      send_word(OP_ADD_SECOND, 16'sh8000, 16'sh8000);
      send_word(OP_COMPUTE, '0, '0);
      send_word(OP_ADD_FIRST, 16'sh7fff, 16'sh8000);
      send_word(OP_ADD_FIRST, 16'sh8000, 16'sh7fff);
      send_word(OP_ADD_SECOND, 16'sh8000, 16'sh8000);
      send_word(OP_ADD_SECOND, 16'sh7fff, 16'sh7fff);
      send_word(OP_NONE, 16'sh7fff, 16'sh7fff);
      send_word(OP_COMPUTE, 16'sh7fff, 16'sh8000);
      send_word(OP_ADD_FIRST, 16'sd0, 16'sd0);
      send_word(OP_ADD_FIRST, 16'sd10, 16'sd0);
      send_word(OP_ADD_FIRST, 16'sd0, 16'sd10);
      send_word(OP_ADD_SECOND, 16'sd20, 16'sd20);
      send_word(OP_ADD_SECOND, 16'sd30, 16'sd20);
      send_word(OP_ADD_SECOND, 16'sd20, 16'sd30);
      send_word(OP_COMPUTE, '0, '0);
      drain();

      // Overflow of the first polygon.
      for (int i = 0; i < MAX_VERTICES + 2; i++)
         send_word(OP_ADD_FIRST, coord_type'($urandom), coord_type'($urandom));
      send_word(OP_ADD_SECOND, 16'sd1, 16'sd1);
      send_word(OP_COMPUTE, '0, '0);
      drain();

      write_limit(7'd1);
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 1) write_limit(7'd64);
         if (phase == 2) write_limit(7'd0);
         if (phase == 3) write_limit(7'd127);
         if (phase == 4) write_limit(iter_type'($urandom_range(1, 64)));
         for (int k = 0; k < 12; k++) begin
            send_pair($urandom_range(1, 6), $urandom_range(1, 6));
            if (k == 6) hold_off = 1;
         end
         if (phase == 2) begin
            send_pair(MAX_VERTICES, MAX_VERTICES);
         end
         drain();
      end
      done = 1;
   end

   // Receiver: its own stall pattern, plus a long hold-off in each phase of the random run.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      hold_off = 0;
      stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            hold_off = 0;
            rsp_if.ready <= 1'b0;
            repeat (3000) @(posedge clock);
         end
         if (stall > 0) begin
            stall--;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 12);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || pending == 0)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (done) begin
            if (failures == 0 && pending == 0)
               $display("CHECK OK");
            else
               $display("CHECK FAILED");
            $finish;
         end else if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule

// ===== filelist.f =====
hdl/cpd_pkg.sv
hdl/cpd_channels.sv
hdl/convex_polygon_distance_unit.sv
verif/convex_polygon_distance_unit_checker.sv
verif/convex_polygon_distance_unit_tb.sv
